// File: design/crs_pkg.sv
`timescale 1ns / 1ps

package crs_pkg;

    // Fixed field widths of the request and result channels.
    localparam int CX_W   = 6;
    localparam int RAD_W  = 5;
    localparam int SEG_W  = 8;
    localparam int ROW_W  = 3;
    localparam int DIG_W  = 4;

    // Internal coordinate width, signed; covers every offset the block forms.
    localparam int COORD_W = 9;

    // Pixel rows of a digit cell that carry segments (the sixth row is blank).
    localparam int LANES = 5;
    localparam int CELL_H = 6;
    localparam int CELL_W = 4;

    // Root of a value below 1024 takes five digit steps.
    localparam int RAD2_W   = 2 * RAD_W;
    localparam int ROOT_STEPS = RAD_W;
    localparam int DYSQ_W  = 12;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [DIG_W-1:0] dig;
        logic             last;
        t_coord           xc;
    } t_ctl;

    typedef struct packed {
        logic [RAD2_W-1:0] rem;
        logic [RAD2_W-1:0] res;
    } t_root;

    // Segment bit lit by each pixel of a 4x6 digit cell.
    localparam logic [SEG_W-1:0] SEG_TAB [CELL_H][CELL_W] = '{
        '{8'h00, 8'h40, 8'h00, 8'h00},
        '{8'h02, 8'h00, 8'h20, 8'h00},
        '{8'h00, 8'h01, 8'h00, 8'h00},
        '{8'h04, 8'h00, 8'h10, 8'h00},
        '{8'h00, 8'h08, 8'h00, 8'h80},
        '{8'h00, 8'h00, 8'h00, 8'h00}
    };

    // One step of the digit-by-digit square root.
    function automatic t_root root_step(t_root s, logic [RAD2_W-1:0] bitv);
        logic [RAD2_W:0] t;
        t_root o;
        t = {1'b0, s.res} + {1'b0, bitv};
        if ({1'b0, s.rem} >= t) begin
            o.rem = s.rem - t[RAD2_W-1:0];
            o.res = (s.res >> 1) + bitv;
        end else begin
            o.rem = s.rem;
            o.res = s.res >> 1;
        end
        return o;
    endfunction

endpackage

// File: design/crs_if.sv
`timescale 1ns / 1ps

interface crs_in_if;
    logic                            valid;
    logic                            ready;
    logic signed [crs_pkg::CX_W-1:0] center_x;
    logic signed [crs_pkg::CX_W-1:0] center_y;
    logic [crs_pkg::RAD_W-1:0]       radius;

    modport source (output valid, output center_x, output center_y, output radius,
                    input ready);
    modport sink   (input valid, input center_x, input center_y, input radius,
                    output ready);
endinterface

interface crs_out_if;
    logic                       valid;
    logic                       ready;
    logic [crs_pkg::SEG_W-1:0]  segments;
    logic [crs_pkg::ROW_W-1:0]  row_index;
    logic [crs_pkg::DIG_W-1:0]  digit_index;
    logic                       last;

    modport source (output valid, output segments, output row_index,
                    output digit_index, output last, input ready);
    modport sink   (input valid, input segments, input row_index,
                    input digit_index, input last, output ready);
endinterface

// File: design/circle_to_segment_raster.sv
`timescale 1ns / 1ps

// Channel   Dir   Handshake              Payload
// i_req     in    i_req.valid/ready      center_x, center_y, radius
// o_res     out   o_res.valid/ready      segments, row_index, digit_index, last
//
// One request yields ROWS*DIGITS result bytes (32 at the default size), one per cycle
// while o_res is ready; the sequencer that walks the digits sets that figure. The
// next request is taken in the cycle the last digit of the current frame is issued.
// Reset is synchronous and active low and empties the pipeline. A stall on o_res
// freezes every stage together, so nothing is lost.
module circle_to_segment_raster #(
    parameter int ROWS   = 4,
    parameter int DIGITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    crs_in_if.sink    i_req,
    crs_out_if.source o_res
);

    // Grid geometry. The crosshair sits at the grid center.
    localparam int GRID_H = ROWS * crs_pkg::CELL_H;
    localparam int MID_X  = DIGITS * crs_pkg::CELL_W / 2;
    localparam int MID_Y  = GRID_H / 2;
    localparam int LN     = crs_pkg::LANES;
    localparam int NS     = crs_pkg::ROOT_STEPS;
    localparam int RW     = crs_pkg::RAD2_W;

    // The whole pipeline moves as one while the output register can take a byte.
    logic w_adv;
    assign w_adv = !o_res.valid || o_res.ready;

    // ------------------------------------------------------------------
    // Sequencer: holds the frame request and walks the digits row by row.
    // ------------------------------------------------------------------
    logic                        r_busy;
    logic [crs_pkg::ROW_W-1:0]   r_row;
    logic [crs_pkg::DIG_W-1:0]   r_dig;
    crs_pkg::t_coord             r_xc;
    crs_pkg::t_coord             r_yc;
    logic [crs_pkg::RAD_W-1:0]   r_rad;

    logic w_issue;
    logic w_final;
    logic w_acc;

    assign w_final     = (r_row == crs_pkg::ROW_W'(ROWS - 1)) &&
                         (r_dig == crs_pkg::DIG_W'(DIGITS - 1));
    assign w_issue     = r_busy && w_adv;
    assign i_req.ready = !r_busy || (w_issue && w_final);
    assign w_acc       = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= '0;
            r_dig  <= '0;
        end else begin
            if (w_acc) begin
                r_busy <= 1'b1;
                r_row  <= '0;
                r_dig  <= '0;
            end else if (w_issue && w_final) begin
                r_busy <= 1'b0;
            end else if (w_issue) begin
                if (r_dig == crs_pkg::DIG_W'(DIGITS - 1)) begin
                    r_dig <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_dig <= r_dig + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_xc  <= crs_pkg::t_coord'(i_req.center_x);
            r_yc  <= crs_pkg::t_coord'(i_req.center_y);
            r_rad <= i_req.radius;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: squares. For each of the five segment-bearing pixel rows of
    // the digit cell, dy is the row's offset from the circle center.
    // ------------------------------------------------------------------
    logic                        r_s1_vld;
    crs_pkg::t_ctl               r_s1_ctl;
    logic [RW-1:0]               r_s1_rr;
    logic [crs_pkg::DYSQ_W-1:0]  r_s1_dysq [LN];

    logic [crs_pkg::DYSQ_W-1:0]  n_s1_dysq [LN];
    crs_pkg::t_ctl               n_s1_ctl;

    always_comb begin
        logic [5:0]             ypix;
        crs_pkg::t_coord        dy;
        logic signed [17:0]     sq;
        for (int k = 0; k < LN; k++) begin
            ypix = 6'(r_row) * 6'(crs_pkg::CELL_H) + 6'(k);
            dy   = $signed({3'b000, ypix}) - crs_pkg::t_coord'(MID_Y) - r_yc;
            sq   = dy * dy;
            n_s1_dysq[k] = sq[crs_pkg::DYSQ_W-1:0];
        end
        n_s1_ctl.row  = r_row;
        n_s1_ctl.dig  = r_dig;
        n_s1_ctl.last = w_final;
        n_s1_ctl.xc   = r_xc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_ctl  <= n_s1_ctl;
            r_s1_rr   <= RW'(r_rad) * RW'(r_rad);
            r_s1_dysq <= n_s1_dysq;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: d2 = r^2 - dy^2. A negative d2 means the row misses the circle.
    // ------------------------------------------------------------------
    logic                 r_s2_vld;
    crs_pkg::t_ctl        r_s2_ctl;
    crs_pkg::t_root       r_s2_root [LN];
    logic [LN-1:0]        r_s2_ok;

    crs_pkg::t_root       n_s2_root [LN];
    logic [LN-1:0]        n_s2_ok;

    always_comb begin
        logic signed [crs_pkg::DYSQ_W:0] d2;
        for (int k = 0; k < LN; k++) begin
            d2 = $signed({3'b000, r_s1_rr}) - $signed({1'b0, r_s1_dysq[k]});
            n_s2_ok[k]       = !d2[crs_pkg::DYSQ_W];
            n_s2_root[k].rem = d2[RW-1:0];
            n_s2_root[k].res = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_adv) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_ctl  <= r_s1_ctl;
            r_s2_root <= n_s2_root;
            r_s2_ok   <= n_s2_ok;
        end
    end

    // ------------------------------------------------------------------
    // Stages 3 to 7: floor square root, one result bit per stage in each lane.
    // ------------------------------------------------------------------
    logic                 r_rt_vld  [NS];
    crs_pkg::t_ctl        r_rt_ctl  [NS];
    crs_pkg::t_root       r_rt_root [NS][LN];
    logic [LN-1:0]        r_rt_ok   [NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) begin
                r_rt_vld[s] <= 1'b0;
            end
        end else if (w_adv) begin
            r_rt_vld[0] <= r_s2_vld;
            for (int s = 1; s < NS; s++) begin
                r_rt_vld[s] <= r_rt_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rt_ctl[0] <= r_s2_ctl;
            r_rt_ok[0]  <= r_s2_ok;
            for (int k = 0; k < LN; k++) begin
                r_rt_root[0][k] <= crs_pkg::root_step(r_s2_root[k],
                                                      RW'(1) << (RW - 2));
            end
            for (int s = 1; s < NS; s++) begin
                r_rt_ctl[s] <= r_rt_ctl[s-1];
                r_rt_ok[s]  <= r_rt_ok[s-1];
                for (int k = 0; k < LN; k++) begin
                    r_rt_root[s][k] <= crs_pkg::root_step(r_rt_root[s-1][k],
                                                          RW'(1) << (RW - 2 - 2 * s));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: outline columns. The left pair sits at xc-dx and one inward,
    // the right pair at xc+dx and one inward, all shifted to grid columns.
    // ------------------------------------------------------------------
    logic                 r_s8_vld;
    crs_pkg::t_ctl        r_s8_ctl;
    crs_pkg::t_coord      r_s8_left  [LN];
    crs_pkg::t_coord      r_s8_right [LN];
    logic [LN-1:0]        r_s8_ok;

    crs_pkg::t_coord      n_s8_left  [LN];
    crs_pkg::t_coord      n_s8_right [LN];

    always_comb begin
        crs_pkg::t_coord dx;
        crs_pkg::t_coord base;
        base = r_rt_ctl[NS-1].xc + crs_pkg::t_coord'(MID_X);
        for (int k = 0; k < LN; k++) begin
            dx = $signed({4'b0000, r_rt_root[NS-1][k].res[crs_pkg::RAD_W-1:0]});
            n_s8_left[k]  = base - dx;
            n_s8_right[k] = base + dx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_vld <= 1'b0;
        end else if (w_adv) begin
            r_s8_vld <= r_rt_vld[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s8_ctl   <= r_rt_ctl[NS-1];
            r_s8_ok    <= r_rt_ok[NS-1];
            r_s8_left  <= n_s8_left;
            r_s8_right <= n_s8_right;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: build the digit byte and hold it in the output register.
    // A pixel is lit on the vertical axis, on the horizontal axis, or on
    // the outline. Only columns of this digit are tested, so pixels off
    // the grid never land anywhere.
    // ------------------------------------------------------------------
    logic [crs_pkg::SEG_W-1:0] n_seg;

    always_comb begin
        crs_pkg::t_coord x;
        logic [5:0]      ypix;
        logic            lit;
        n_seg = '0;
        for (int k = 0; k < LN; k++) begin
            ypix = 6'(r_s8_ctl.row) * 6'(crs_pkg::CELL_H) + 6'(k);
            for (int j = 0; j < crs_pkg::CELL_W; j++) begin
                x   = $signed({3'b000, r_s8_ctl.dig, 2'(j)});
                lit = (x == crs_pkg::t_coord'(MID_X)) ||
                      (ypix == 6'(MID_Y)) ||
                      (r_s8_ok[k] && ((x == r_s8_left[k]) ||
                                      (x == r_s8_left[k] + 9'sd1) ||
                                      (x == r_s8_right[k]) ||
                                      (x == r_s8_right[k] - 9'sd1)));
                if (lit) begin
                    n_seg = n_seg | crs_pkg::SEG_TAB[k][j];
                end
            end
        end
    end

    logic                      r_out_vld;
    logic [crs_pkg::SEG_W-1:0] r_out_seg;
    crs_pkg::t_ctl             r_out_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_s8_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_seg <= n_seg;
            r_out_ctl <= r_s8_ctl;
        end
    end

    assign o_res.valid       = r_out_vld;
    assign o_res.segments    = r_out_seg;
    assign o_res.row_index   = r_out_ctl.row;
    assign o_res.digit_index = r_out_ctl.dig;
    assign o_res.last        = r_out_ctl.last;

endmodule

// File: design/crs_checker.sv
`timescale 1ns / 1ps

module crs_checker #(
    parameter int ROWS   = 4,
    parameter int DIGITS = 8
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [crs_pkg::SEG_W-1:0] i_segments,
    input logic [crs_pkg::ROW_W-1:0] i_row_index,
    input logic [crs_pkg::DIG_W-1:0] i_digit_index,
    input logic                      i_last
);

    // The vertical axis falls in the middle digit, on its left column when
    // DIGITS is even and on its right-center column when it is odd.
    localparam int AXIS_DIG = DIGITS / 2;
    localparam logic [crs_pkg::SEG_W-1:0] AXIS_MASK =
        (DIGITS % 2 == 0) ? 8'h06 : 8'h30;

    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last |->
            (i_row_index == crs_pkg::ROW_W'(ROWS - 1)) &&
            (i_digit_index == crs_pkg::DIG_W'(DIGITS - 1)))
        else $error("last flag on a byte that is not the final digit");

    a_axis_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_digit_index == crs_pkg::DIG_W'(AXIS_DIG)) |->
            ((i_segments & AXIS_MASK) == AXIS_MASK))
        else $error("vertical axis segments missing");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_segments) && $stable(i_row_index) &&
            $stable(i_digit_index) && $stable(i_last))
        else $error("stalled result changed");

endmodule

bind circle_to_segment_raster crs_checker #(
    .ROWS   (ROWS),
    .DIGITS (DIGITS)
) u_crs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_segments    (o_res.segments),
    .i_row_index   (o_res.row_index),
    .i_digit_index (o_res.digit_index),
    .i_last        (o_res.last)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps

// Frame-level check of circle_to_segment_raster. Each request (circle centre
// and radius) is expected to produce one segment byte per digit of the
// 4 x 8 digit grid, row by row, with the flag set on the final byte. The
// bench computes every expected byte itself from the request fields. The
// predictor paints the crosshair and the circle outline pixel by pixel into
// a local frame buffer, folding each pixel into its digit as it goes through the
// fixed cell-to-segment map, and queues the bytes. Returned bytes are matched
// in order against that queue.
module testbench;

    // Grid geometry at the block's default size.
    localparam int ROWS    = 4;
    localparam int DIGITS  = 8;
    localparam int GRID_W  = DIGITS * crs_pkg::CELL_W;
    localparam int GRID_H  = ROWS * crs_pkg::CELL_H;
    localparam int MID_X   = GRID_W / 2;
    localparam int MID_Y   = GRID_H / 2;
    localparam int CELLS   = ROWS * DIGITS;

    // The idle limit covers a frame's trip through the pipeline, one worst-case receiver
    // stall and one sender gap, then takes a wide margin.
    localparam int STALL_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [crs_pkg::SEG_W-1:0] segments;
        logic [crs_pkg::ROW_W-1:0] row_index;
        logic [crs_pkg::DIG_W-1:0] digit_index;
        logic                      last;
    } t_digit_byte;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    crs_in_if  req_if ();
    crs_out_if res_if ();

    circle_to_segment_raster #(
        .ROWS   (ROWS),
        .DIGITS (DIGITS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_res   (res_if.source)
    );

    always #5 i_clk = ~i_clk;

    // Bytes still owed by the block, oldest first.
    t_digit_byte               pending_bytes [$];
    // Scratch frame that the predictor paints into.
    logic [crs_pkg::SEG_W-1:0] frame_bytes [CELLS];

    int failures    = 0;
    int idle_cycles = 0;
    int stall_left  = 0;
    // While set, both sides insert random idle bursts.
    bit gaps_on     = 1'b1;

    // Segment bit lit by one pixel of a 4-wide, 6-high digit cell. Only the
    // eight pixels that sit on a segment carry a bit; the bottom row is blank.
    function automatic logic [crs_pkg::SEG_W-1:0] cell_segment(int py, int px);
        case (py * crs_pkg::CELL_W + px)
            1:       return 8'h40;
            4:       return 8'h02;
            6:       return 8'h20;
            9:       return 8'h01;
            12:      return 8'h04;
            14:      return 8'h10;
            17:      return 8'h08;
            19:      return 8'h80;
            default: return 8'h00;
        endcase
    endfunction

    function automatic int floor_root(int v);
        int s;
        s = 0;
        while ((s + 1) * (s + 1) <= v) s++;
        return s;
    endfunction

    // Pixels that fall off the grid on any side are simply dropped.
    function automatic void light_pixel(int x, int y);
        if (x < 0 || y < 0 || x >= GRID_W || y >= GRID_H) return;
        frame_bytes[(y / crs_pkg::CELL_H) * DIGITS + x / crs_pkg::CELL_W] |=
            cell_segment(y % crs_pkg::CELL_H, x % crs_pkg::CELL_W);
    endfunction

    // Paint one frame and queue its bytes in output order.
    function automatic void predict_frame(int cx, int cy, int r);
        int          dy;
        int          d2;
        int          dx;
        t_digit_byte b;
        for (int i = 0; i < CELLS; i++) frame_bytes[i] = '0;
        for (int y = 0; y < GRID_H; y++) light_pixel(MID_X, y);
        for (int x = 0; x < GRID_W; x++) light_pixel(x, MID_Y);
        // Each pixel row that meets the circle lights both outline pixels
        // and their inward neighbours; rows beyond the radius light nothing.
        for (int y = -MID_Y; y < MID_Y; y++) begin
            dy = y - cy;
            d2 = r * r - dy * dy;
            if (d2 >= 0) begin
                dx = floor_root(d2);
                light_pixel(cx - dx + MID_X, y + MID_Y);
                light_pixel(cx - dx + 1 + MID_X, y + MID_Y);
                light_pixel(cx + dx + MID_X, y + MID_Y);
                light_pixel(cx + dx - 1 + MID_X, y + MID_Y);
            end
        end
        for (int i = 0; i < CELLS; i++) begin
            b.segments    = frame_bytes[i];
            b.row_index   = crs_pkg::ROW_W'(i / DIGITS);
            b.digit_index = crs_pkg::DIG_W'(i % DIGITS);
            b.last        = (i == CELLS - 1);
            pending_bytes.push_back(b);
        end
    endfunction

    // Present one request and hold it until the block takes it. Valid is
    // left high on return so that a following request can go out in the
    // very next cycle without valid dropping in between.
    task automatic send_request(input int cx, input int cy, input int r);
        int                               gap;
        logic signed [crs_pkg::CX_W-1:0]  sx;
        logic signed [crs_pkg::CX_W-1:0]  sy;
        logic        [crs_pkg::RAD_W-1:0] sr;
        sx  = cx[crs_pkg::CX_W-1:0];
        sy  = cy[crs_pkg::CX_W-1:0];
        sr  = r[crs_pkg::RAD_W-1:0];
        gap = 0;
        if (gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.center_x <= sx;
        req_if.center_y <= sy;
        req_if.radius   <= sr;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predict_frame(int'(sx), int'(sy), int'(sr));
    endtask

    // Hand-picked frames: field extremes, a zero radius, a circle whose rows
    // all miss, circles that run off each edge of the grid, and a few
    // ordinary ones.
    task automatic test_directed();
        send_request(0, 0, 0);
        send_request(0, 0, 31);
        send_request(-32, -32, 31);
        send_request(31, 31, 31);
        send_request(-32, 31, 0);
        send_request(31, -32, 0);
        send_request(0, 0, 1);
        send_request(-1, -1, 1);
        send_request(1, 0, 2);
        send_request(0, -20, 4);
        send_request(-32, 0, 5);
        send_request(31, 0, 3);
        send_request(0, -32, 4);
        send_request(0, 31, 4);
        send_request(-16, -12, 6);
        send_request(15, 11, 6);
        send_request(-17, 0, 0);
        send_request(16, 0, 0);
        send_request(0, 12, 0);
        send_request(0, -13, 0);
        send_request(5, 3, 7);
        send_request(-7, 4, 12);
        send_request(10, -5, 20);
        send_request(-21, 9, 17);
    endtask

    // Mostly circles centred near the grid so that outlines land on it, and
    // a quarter drawn from the full field ranges. Idling is switched on and
    // off in blocks so that quiet stretches appear as well.
    task automatic test_random();
        int cx;
        int cy;
        int r;
        for (int i = 0; i < 196; i++) begin
            if (i % 20 == 0) gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0) begin
                cx = int'($urandom_range(0, 63)) - 32;
                cy = int'($urandom_range(0, 63)) - 32;
                r  = int'($urandom_range(0, 31));
            end else begin
                cx = int'($urandom_range(0, 40)) - 20;
                cy = int'($urandom_range(0, 30)) - 15;
                r  = int'($urandom_range(0, 16));
            end
            send_request(cx, cy, r);
        end
    endtask

    // Last part of the run: no idling on either side, requests back to back.
    task automatic test_full_rate();
        gaps_on = 1'b0;
        for (int i = 0; i < 40; i++) begin
            send_request(int'($urandom_range(0, 63)) - 32,
                         int'($urandom_range(0, 30)) - 15,
                         int'($urandom_range(0, 31)));
        end
    endtask

    task automatic report_mismatch(input string what, input t_digit_byte want,
                                   input t_digit_byte got);
        failures++;
        if (failures <= MAX_REPORTS) begin
            $display({"%0t: %s: expected seg=%h row=%0d dig=%0d last=%b, ",
                      "got seg=%h row=%0d dig=%0d last=%b"},
                     $realtime, what, want.segments, want.row_index, want.digit_index,
                     want.last, got.segments, got.row_index, got.digit_index, got.last);
        end
    endtask

    // Receiver side: ready drops for random bursts.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            res_if.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 4);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // Every byte the block hands over is matched against the oldest one owed.
    always @(posedge i_clk) begin
        t_digit_byte got;
        t_digit_byte want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.segments    = res_if.segments;
            got.row_index   = res_if.row_index;
            got.digit_index = res_if.digit_index;
            got.last        = res_if.last;
            if (pending_bytes.size() == 0) begin
                report_mismatch("byte with no frame pending", '0, got);
            end else begin
                want = pending_bytes.pop_front();
                if (got.segments !== want.segments || got.row_index !== want.row_index ||
                    got.digit_index !== want.digit_index || got.last !== want.last) begin
                    report_mismatch("byte mismatch", want, got);
                end
            end
        end
    end

    // A hung block shows up as a long run of cycles with no transfer on
    // either channel.
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("testbench failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        req_if.valid    <= 1'b0;
        req_if.center_x <= '0;
        req_if.center_y <= '0;
        req_if.radius   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random();
        test_full_rate();

        // The last request was taken at this edge; valid can drop now.
        req_if.valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        // Leave room for any stray byte the block might still push out.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/crs_pkg.sv
design/crs_if.sv
design/circle_to_segment_raster.sv
design/crs_checker.sv
tb/testbench.sv
